[hdl/tcou_pkg.sv]
// Package for the telecontrol object unpacker: transaction types, parse state
// and the message-kind and command codes. No dependencies.
package tcou_pkg;

    // command field
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // message kinds carried on a start transaction
    localparam logic [1:0] KIND_BITS        = 2'd0;
    localparam logic [1:0] KIND_FLOAT       = 2'd1;
    localparam logic [1:0] KIND_INTERROGATE = 2'd2;
    localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

    // bytes per address and per value
    localparam logic [2:0] ADDR_BYTES  = 3'd3;
    localparam logic [2:0] VALUE_BYTES = 3'd4;

    typedef struct packed {
        logic       command;
        logic [1:0] message_kind;
        logic [6:0] object_count;
        logic       own_address_each;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [23:0] object_address;
        logic [31:0] value_bits;
        logic [7:0]  quality;
        logic        value_is_float;
    } t_out_item;

    typedef struct packed {
        logic [23:0] cur_addr;
        logic [31:0] value_gather;
        logic [2:0]  byte_pos;
        logic [6:0]  objects_done;
        logic [6:0]  objects_total;
        logic [1:0]  kind_held;
        logic        addr_mode;
        logic        addr_phase;
        logic        running;
    } t_parse_state;

endpackage

[hdl/tcou_step.sv]
// Next-state and result logic for one transaction of the object unpacker.
// Purely combinational; depends on tcou_pkg.
module tcou_step import tcou_pkg::*; (
    input  t_parse_state i_state,
    input  t_in_item     i_item,
    output t_parse_state o_state,
    output logic         o_emit,
    output t_out_item    o_result
);

    logic        finish;
    logic [2:0]  pos_inc;
    logic [6:0]  done_inc;
    logic [31:0] byte_ext;
    logic [4:0]  byte_shift;

    assign pos_inc    = i_state.byte_pos + 3'd1;
    assign done_inc   = i_state.objects_done + 7'd1;
    assign byte_ext   = {24'd0, i_item.data_byte};
    assign byte_shift = {i_state.byte_pos[1:0], 3'b000};

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        finish   = 1'b0;
        o_result = '{object_address: i_state.cur_addr,
                     value_bits:     i_state.value_gather,
                     quality:        i_item.data_byte,
                     value_is_float: (i_state.kind_held == KIND_FLOAT)};

        if (i_item.command == CMD_START) begin
            o_state.kind_held     = i_item.message_kind;
            o_state.objects_total = i_item.object_count;
            o_state.objects_done  = 7'd0;
            o_state.addr_mode     = i_item.own_address_each;
            o_state.addr_phase    = 1'b1;
            o_state.byte_pos      = 3'd0;
            o_state.cur_addr      = 24'd0;
            o_state.value_gather  = 32'd0;
            o_state.running       = (i_item.object_count != 7'd0) &&
                                    (i_item.message_kind != KIND_UNSUPPORTED);
        end else if (i_state.running) begin
            if (i_state.addr_phase) begin
                // little-endian address; first byte clears the old address
                case (i_state.byte_pos[1:0])
                    2'd0:    o_state.cur_addr = {16'd0, i_item.data_byte};
                    2'd1:    o_state.cur_addr = i_state.cur_addr |
                                                {8'd0, i_item.data_byte, 8'd0};
                    2'd2:    o_state.cur_addr = i_state.cur_addr |
                                                {i_item.data_byte, 16'd0};
                    default: o_state.cur_addr = i_state.cur_addr;
                endcase
                o_state.byte_pos = pos_inc;
                if (pos_inc >= ADDR_BYTES) begin
                    o_state.byte_pos     = 3'd0;
                    o_state.addr_phase   = 1'b0;
                    o_state.value_gather = 32'd0;
                end
            end else if (i_state.kind_held == KIND_INTERROGATE) begin
                finish = 1'b1;   // group byte, nothing emitted
            end else if (i_state.kind_held != KIND_BITS &&
                         i_state.kind_held != KIND_FLOAT) begin
                o_state.running = 1'b0;
            end else if (i_state.byte_pos < VALUE_BYTES) begin
                o_state.value_gather = i_state.value_gather | (byte_ext << byte_shift);
                o_state.byte_pos     = pos_inc;
            end else begin
                o_emit = 1'b1;   // quality byte closes the object
                finish = 1'b1;
            end
        end

        if (finish) begin
            o_state.objects_done = done_inc;
            o_state.byte_pos     = 3'd0;
            o_state.value_gather = 32'd0;
            if (done_inc >= i_state.objects_total) begin
                o_state.running = 1'b0;
            end else if (i_state.addr_mode) begin
                o_state.addr_phase = 1'b1;
            end else begin
                o_state.cur_addr   = i_state.cur_addr + 24'd1;
                o_state.addr_phase = 1'b0;
            end
        end
    end

endmodule

[hdl/telecontrol_object_unpacker.sv]
// Path: the data transaction that closes an object is held in the input register,
// and its result is then loaded into the result register and leaves from there.
// Throughput: one transaction per cycle while the result stage is not stalled; the state update is the limit.
// Reset: synchronous, active low; parser stopped, both stages empty.
// Top level of the telecontrol object unpacker; depends on tcou_pkg, tcou_step.
module telecontrol_object_unpacker import tcou_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam t_parse_state STATE_RESET = '{
        cur_addr:      24'd0,
        value_gather:  32'd0,
        byte_pos:      3'd0,
        objects_done:  7'd0,
        objects_total: 7'd0,
        kind_held:     KIND_UNSUPPORTED,
        addr_mode:     1'b0,
        addr_phase:    1'b1,
        running:       1'b0
    };

    // input register
    logic         r_in_valid;
    t_in_item     r_in_item;
    // parse state
    t_parse_state r_state;
    t_parse_state n_state;
    // result register
    logic         r_out_valid;
    t_out_item    r_out_item;
    logic         n_emit;
    t_out_item    n_result;

    logic advance;      // the held transaction is processed this cycle
    logic in_accept;

    // The result register is free when empty or being drained this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    // Back-pressure only while a held transaction cannot move on.
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    tcou_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_emit   (n_emit),
        .o_result (n_result)
    );

    // Input stage: refills whenever it empties or its transaction moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Parse state moves once per processed transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // Result stage: holds while stalled, otherwise loads what the step emits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && n_emit) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hdl/tcou_checker.sv]
// Port-level checks for the telecontrol object unpacker, bound to the top.
// Depends on tcou_pkg and telecontrol_object_unpacker.
module tcou_checker import tcou_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    // Upstream back-pressure only comes from a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // The input is never stalled while the result stage is empty.
    a_drain_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with result stage empty");

    // A stalled input transaction is still offered, unchanged, next cycle.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input transaction changed");

endmodule

bind telecontrol_object_unpacker tcou_checker u_tcou_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

[tb/tcou_scoreboard.sv]
`timescale 1ns / 1ps
// Scoreboard for the telecontrol object unpacker: a parse predictor and the
// queue of decoded objects still due. Depends on tcou_pkg.
package tcou_tb_pkg;
    import tcou_pkg::*;

    class tcou_scoreboard;
        t_out_item   due_objects[$];
        int unsigned mismatch_count;
        int unsigned objects_checked;

        // predicted parse state
        logic [23:0] cur_addr;
        logic [31:0] gather;
        logic [2:0]  byte_pos;
        logic [6:0]  objects_done;
        logic [6:0]  objects_total;
        logic [1:0]  kind_held;
        logic        addr_mode;
        logic        addr_phase;
        logic        running;

        function new();
            cur_addr        = '0;
            gather          = '0;
            byte_pos        = '0;
            objects_done    = '0;
            objects_total   = '0;
            kind_held       = KIND_UNSUPPORTED;
            addr_mode       = 1'b0;
            addr_phase      = 1'b1;
            running         = 1'b0;
            mismatch_count  = 0;
            objects_checked = 0;
        endfunction

        function void close_object();
            objects_done = objects_done + 7'd1;
            byte_pos     = '0;
            gather       = '0;
            if (objects_done >= objects_total) begin
                running = 1'b0;
            end else if (addr_mode) begin
                addr_phase = 1'b1;
            end else begin
                cur_addr   = cur_addr + 24'd1;
                addr_phase = 1'b0;
            end
        endfunction

        // Returns 1 when the transaction moved the parse (not ignored).
        function bit note_input(t_in_item it);
            t_out_item obj;
            if (it.command == CMD_START) begin
                kind_held     = it.message_kind;
                objects_total = it.object_count;
                objects_done  = '0;
                addr_mode     = it.own_address_each;
                addr_phase    = 1'b1;
                byte_pos      = '0;
                cur_addr      = '0;
                gather        = '0;
                running       = (it.object_count != 7'd0) &&
                                (it.message_kind != KIND_UNSUPPORTED);
                return 1'b1;
            end
            if (!running) begin
                return 1'b0;
            end
            if (addr_phase) begin
                if (byte_pos == 3'd0) begin
                    cur_addr = '0;
                end
                cur_addr = cur_addr | (24'(it.data_byte) << (8 * byte_pos));
                byte_pos = byte_pos + 3'd1;
                if (byte_pos >= ADDR_BYTES) begin
                    byte_pos   = '0;
                    addr_phase = 1'b0;
                    gather     = '0;
                end
            end else if (kind_held == KIND_INTERROGATE) begin
                close_object();
            end else if (kind_held != KIND_BITS && kind_held != KIND_FLOAT) begin
                running = 1'b0;
            end else if (byte_pos < VALUE_BYTES) begin
                gather   = gather | (32'(it.data_byte) << (8 * byte_pos));
                byte_pos = byte_pos + 3'd1;
            end else begin
                obj.object_address = cur_addr;
                obj.value_bits     = gather;
                obj.quality        = it.data_byte;
                obj.value_is_float = (kind_held == KIND_FLOAT);
                due_objects.push_back(obj);
                close_object();
            end
            return 1'b1;
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_objects.size() == 0) begin
                $error("object %h emitted with none due", got);
                mismatch_count++;
                return;
            end
            want = due_objects.pop_front();
            objects_checked++;
            if (got.object_address !== want.object_address) begin
                $error("object_address: expected %h, got %h",
                       want.object_address, got.object_address);
                mismatch_count++;
            end
            if (got.value_bits !== want.value_bits) begin
                $error("value_bits: expected %h, got %h", want.value_bits, got.value_bits);
                mismatch_count++;
            end
            if (got.quality !== want.quality) begin
                $error("quality: expected %h, got %h", want.quality, got.quality);
                mismatch_count++;
            end
            if (got.value_is_float !== want.value_is_float) begin
                $error("value_is_float: expected %b, got %b",
                       want.value_is_float, got.value_is_float);
                mismatch_count++;
            end
        endfunction

        function int due_count();
            return due_objects.size();
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the telecontrol object unpacker: drives ASDU headers and
// object bytes, checks decoded objects. Depends on tcou_pkg and tcou_tb_pkg.
module tb_top;
    import tcou_pkg::*;
    import tcou_tb_pkg::*;

    localparam int EFFECTIVE_ITEMS = 1350;
    localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
    localparam int IDLE_LIMIT      = 2000;  // watchdog: cycles with no transaction
    localparam int TAIL_CYCLES     = 10;    // pipeline is two stages deep

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    // stimulus-side controls shared with the receiver
    bit        quiet     = 1'b0;  // no idling on either side
    bit        hold_req  = 1'b0;  // ask the receiver for a long hold-off

    int unsigned n_effective = 0;  // transactions that moved the parse
    int unsigned n_starts    = 0;
    int unsigned n_cut       = 0;  // truncated or abandoned ASDUs

    tcou_scoreboard unpack_sb;

    always #10 clk = ~clk;

    telecontrol_object_unpacker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    // Offer one transaction and hold it until accepted. Returns in the time
    // step of acceptance with valid still high; the caller either offers the
    // next transaction right away or lowers valid in that same step.
    task automatic send_item(input t_in_item it);
        if (!quiet) begin
            // idle cycles at roughly 12 in a hundred
            while ($urandom_range(99) < 12) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (unpack_sb.note_input(it)) begin
            n_effective++;
        end
    endtask

    // Header transaction; the data byte is don't-care and left random.
    task automatic send_start(input logic [1:0] kind, input logic [6:0] count,
                              input logic own);
        t_in_item it;
        it                  = t_in_item'($urandom);
        it.command          = CMD_START;
        it.message_kind     = kind;
        it.object_count     = count;
        it.own_address_each = own;
        n_starts++;
        send_item(it);
    endtask

    // Data transaction; header fields are don't-care and left random.
    task automatic send_data(input logic [7:0] b);
        t_in_item it;
        it           = t_in_item'($urandom);
        it.command   = CMD_DATA;
        it.data_byte = b;
        send_item(it);
    endtask

    // Bytes in a complete object area.
    function automatic int asdu_length(input logic [1:0] kind, input logic [6:0] count,
                                       input logic own);
        int first_len;
        int next_len;
        if (count == 7'd0 || kind == KIND_UNSUPPORTED) begin
            return 0;
        end
        first_len = (kind == KIND_INTERROGATE) ? 1 + int'(ADDR_BYTES)
                                                : 1 + int'(VALUE_BYTES) + int'(ADDR_BYTES);
        next_len  = own ? first_len : first_len - int'(ADDR_BYTES);
        return first_len + (int'(count) - 1) * next_len;
    endfunction

    // A whole ASDU with random bytes. cut >= 0 stops after that many bytes;
    // extra bytes past the end should be ignored by the block.
    task automatic send_asdu(input logic [1:0] kind, input logic [6:0] count,
                             input logic own, input int cut, input int extra);
        int len;
        len = asdu_length(kind, count, own);
        if (cut >= 0 && cut < len) begin
            len = cut;
            n_cut++;
        end
        send_start(kind, count, own);
        for (int i = 0; i < len + extra; i++) begin
            send_data(8'($urandom_range(255)));
        end
    endtask

    // Lower valid and wait until every due object has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (unpack_sb.due_count() != 0);
    endtask

    // Receiver: checks accepted results and drives stall. The long hold-off
    // is counted here so the sender keeps pushing while the block backs up.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                unpack_sb.check_result(out_item);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (quiet) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < 12);
            end
        end
    end

    // Watchdog: ends the run once nothing moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAIL telecontrol_object_unpacker");
        $finish;
    end

    // Main stimulus
    initial begin
        int          r;
        int          len;
        int          cut;
        int          extra;
        logic [1:0]  kind;
        logic [6:0]  count;
        logic        own;
        bit          hold_done;
        bit          pause_done;
        t_in_item    noise;

        unpack_sb  = new();
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        send_data(8'hA5);                       // data while stopped: ignored
        send_start(KIND_BITS, 7'd0, 1'b1);      // zero count stops at once
        send_data(8'h5A);
        send_start(KIND_UNSUPPORTED, 7'd3, 1'b0); // unsupported kind stops at once
        send_data(8'h3C);
        send_start(KIND_BITS, 7'd1, 1'b0);      // truncated mid-address ...
        send_data(8'h12);
        send_data(8'h34);
        n_cut++;
        // ... abandoned by a new start; all-ones address wraps to zero
        send_start(KIND_FLOAT, 7'd2, 1'b0);
        repeat (3) send_data(8'hFF);
        repeat (4) send_data(8'hFF);
        send_data(8'hFF);
        repeat (4) send_data(8'h00);
        send_data(8'h00);
        // interrogation, own addresses; the byte after the count is ignored
        send_start(KIND_INTERROGATE, 7'd1, 1'b1);
        send_data(8'h00);
        send_data(8'h80);
        send_data(8'h7F);
        send_data(8'h14);
        send_data(8'hC3);

        // largest count, run to the end with sequential addressing
        send_asdu(KIND_INTERROGATE, 7'd127, 1'b0, -1, 2);

        // ---- random part ----
        while (n_effective < EFFECTIVE_ITEMS) begin
            if (!hold_done && n_effective >= 400) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && n_effective >= 800) begin
                drain_results();
                pause_done = 1'b1;
            end
            quiet = (n_effective >= 900 && n_effective < 1150);

            r = $urandom_range(99);
            if (r < 70) begin
                // well-formed ASDU, mostly short, at times cut short or with extra bytes
                kind  = 2'($urandom_range(2));
                count = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 1))
                                                 : 7'($urandom_range(4, 1));
                own   = 1'($urandom_range(1));
                len   = asdu_length(kind, count, own);
                cut   = -1;
                if (count > 7'd8) begin
                    cut = $urandom_range((len > 60) ? 59 : len - 1, 0);
                end else if ($urandom_range(99) < 15) begin
                    cut = $urandom_range(len - 1, 0);
                end
                extra = ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0;
                send_asdu(kind, count, own, cut, extra);
            end else if (r < 85) begin
                // noise: one fully random transaction
                noise = t_in_item'($urandom);
                if (noise.command == CMD_START) begin
                    n_starts++;
                end
                send_item(noise);
            end else begin
                // broken: random header, random short run of bytes
                kind  = 2'($urandom_range(3));
                count = 7'($urandom_range(127));
                own   = 1'($urandom_range(1));
                send_asdu(kind, count, own, $urandom_range(12), 0);
            end
        end
        quiet = 1'b0;

        // ---- wind down ----
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d ASDU starts (%0d cut short), %0d decoded objects checked,",
                 n_starts, n_cut, unpack_sb.objects_checked);
        $display("  %0d parse transactions, receiver hold-off and a drain pause",
                 n_effective);
        if (unpack_sb.mismatch_count == 0) begin
            $display("PASS telecontrol_object_unpacker");
        end else begin
            $display("FAIL telecontrol_object_unpacker");
        end
        $finish;
    end

endmodule
